// ===== rtl/bcd_pkg.sv =====
// Shared types, widths and constants for the button chord detector.
// Holds the fixed axis table as a lookup function; no dependencies.
package bcd_pkg;

   localparam int SLOT_W         = 6;
   localparam int VALUE_W        = 16;
   localparam int TIME_W         = 32;
   localparam int MASK_W         = 64;
   localparam int THR_W          = 16;
   localparam int NUM_BUTTONS_DEF = 64;
   localparam int NUM_AXES       = 8;
   localparam int ROM_AXES       = 8;
   localparam int ROM_IDX_W      = 3;
   localparam logic [THR_W-1:0] THR_RESET = 16'd250;

   localparam logic [VALUE_W-1:0] AX_MIN  = 16'h8000;  // -32768
   localparam logic [VALUE_W-1:0] AX_MAX  = 16'h7FFF;  // 32767
   localparam logic [VALUE_W-1:0] AX_MID  = 16'd128;
   localparam logic [VALUE_W-1:0] AX_FULL = 16'd255;
   localparam logic [VALUE_W-1:0] AX_ZERO = 16'd0;
   localparam logic [VALUE_W-1:0] AX_NEG1 = 16'hFFFF;
   localparam logic [VALUE_W-1:0] AX_POS1 = 16'd1;

   localparam logic [VALUE_W-1:0] BTN_PRESS   = 16'd1;
   localparam logic [VALUE_W-1:0] BTN_RELEASE = 16'd0;

   typedef struct packed {
      logic [VALUE_W-1:0] neutral;
      logic [VALUE_W-1:0] press_a;
      logic [VALUE_W-1:0] press_b;
      logic [SLOT_W-1:0]  slot_a;
      logic [SLOT_W-1:0]  slot_b;
      logic               has_a;
      logic               has_b;
   } axis_rom_type;

   // status from the shared time compare unit
   typedef struct packed {
      logic ge_thr;    // now - entry >= threshold
      logic gt_thr;    // now - entry >  threshold
      logic earlier;   // ref - entry >  0
   } cmp_status_type;

   function automatic axis_rom_type bcd_axis_rom(input logic [ROM_IDX_W-1:0] idx);
      axis_rom_type r;
      case (idx)
         3'd0: r = '{AX_ZERO, AX_MIN, AX_MAX, 6'd15, 6'd14, 1'b1, 1'b1};
         3'd1: r = '{AX_ZERO, AX_MIN, AX_MAX, 6'd16, 6'd17, 1'b1, 1'b1};
         3'd2: r = '{AX_MID, AX_ZERO, AX_FULL, 6'd22, 6'd0, 1'b1, 1'b0};
         3'd3: r = '{AX_ZERO, AX_MIN, AX_MAX, 6'd19, 6'd18, 1'b1, 1'b1};
         3'd4: r = '{AX_ZERO, AX_MIN, AX_MAX, 6'd20, 6'd21, 1'b1, 1'b1};
         3'd5: r = '{AX_MID, AX_ZERO, AX_FULL, 6'd23, 6'd0, 1'b1, 1'b0};
         3'd6: r = '{AX_ZERO, AX_NEG1, AX_POS1, 6'd11, 6'd10, 1'b1, 1'b1};
         3'd7: r = '{AX_ZERO, AX_NEG1, AX_POS1, 6'd12, 6'd13, 1'b1, 1'b1};
         default: r = '{AX_ZERO, AX_ZERO, AX_ZERO, 6'd0, 6'd0, 1'b0, 1'b0};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bcd_channels.sv =====
// Valid/ready channel interfaces for event words and chord words.
// Depends on bcd_pkg for field widths.
interface bcd_req_if;
   import bcd_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SLOT_W-1:0]   slot;
   logic signed [VALUE_W-1:0] value;
   logic [TIME_W-1:0]   time_ms;
   modport source (output valid, output mode, output slot, output value, output time_ms,
                   input ready);
   modport sink (input valid, input mode, input slot, input value, input time_ms,
                 output ready);
endinterface

interface bcd_rsp_if;
   import bcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [MASK_W-1:0]   held_mask;
   logic [SLOT_W-1:0]   final_button;
   modport source (output valid, output held_mask, output final_button, input ready);
   modport sink (input valid, input held_mask, input final_button, output ready);
endinterface

// ===== rtl/button_chord_detector_unit.sv =====
// Button chord detector top level: event sequencer, press-time RAM and
// result register. Depends on bcd_pkg, bcd_channels, bcd_ram, bcd_time_cmp.
//
// Usage:
//   req_chan carries one event word (mode, slot, value, time_ms). Button
//   events press or release a slot; axis events go through the fixed axis
//   table and hold at most one virtual button at a time.
//   rsp_chan carries one chord word (held_mask, final_button) for each
//   release that comes sooner than hold_threshold_ms after its press.
//   csr_wr_en / csr_wr_data write hold_threshold_ms; write only while idle.
// Timing:
//   On presses and ignored events req_chan.ready stays high.
//   A release held hold_threshold_ms or longer passes through ST_CHK, no chord.
//   A chord release goes through ST_CHK to read and compare the released
//   press time, ST_SCAN for one RAM read and compare per slot through the
//   shared compare unit, and ST_DONE to post the result.
//   Ready is low from the accepted release until the result is posted.
// Reset: flags, axis lock state and the threshold (250) are cleared/loaded
//   at once; the press-time RAM needs no clearing pass.
// Stall: a finished chord waits in the output register; new events are
//   taken meanwhile, and only a second chord waits for the first to leave.
module button_chord_detector_unit #(
   parameter int NUM_BUTTONS = bcd_pkg::NUM_BUTTONS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   bcd_req_if.sink                   req_chan,
   bcd_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [bcd_pkg::THR_W-1:0] csr_wr_data
);
   import bcd_pkg::*;

   localparam int IDX_W = $clog2(NUM_BUTTONS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CHK  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [NUM_BUTTONS-1:0] flags_ff, flags_in;
   logic                   lock_ff, lock_in;
   logic                   abv_ff, abv_in;
   logic [SLOT_W-1:0]      abs_ff, abs_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       rel_slot_ff, rel_slot_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [TIME_W-1:0]      pts_ff, pts_in;
   logic [NUM_BUTTONS-1:0] mask_ff, mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   logic                   accept;
   logic                   do_press;
   logic                   do_release;
   logic [IDX_W-1:0]       press_slot;
   logic [IDX_W-1:0]       rel_slot;
   logic [IDX_W-1:0]       rd_addr;
   logic [TIME_W-1:0]      rd_data;
   logic                   load_rsp;
   logic                   hit;
   axis_rom_type           rom;
   cmp_status_type         cmp;

   assign accept = req_chan.valid && req_chan.ready;
   assign rom    = bcd_axis_rom(req_chan.slot[ROM_IDX_W-1:0]);

   bcd_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_BUTTONS)
   ) u_press_time (
      .clock   (clock),
      .wr_en   (do_press),
      .wr_addr (press_slot),
      .wr_data (req_chan.time_ms),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bcd_time_cmp u_cmp (
      .now_time   (time_ff),
      .ref_time   (pts_ff),
      .entry_time (rd_data),
      .threshold  (thr_ff),
      .status     (cmp)
   );

   // event decode, only acted on at an accepting edge
   always_comb begin
      logic              found;
      logic [SLOT_W-1:0] ax_slot;
      found      = 1'b0;
      ax_slot    = '0;
      do_press   = 1'b0;
      do_release = 1'b0;
      press_slot = req_chan.slot[IDX_W-1:0];
      rel_slot   = req_chan.slot[IDX_W-1:0];
      lock_in    = lock_ff;
      abv_in     = abv_ff;
      abs_in     = abs_ff;
      if (accept) begin
         if (!req_chan.mode) begin
            if ({1'b0, req_chan.slot} < (SLOT_W+1)'(NUM_BUTTONS)) begin
               if (req_chan.value == BTN_PRESS) begin
                  do_press = 1'b1;
               end else if (req_chan.value == BTN_RELEASE) begin
                  do_release = flags_ff[req_chan.slot[IDX_W-1:0]];
               end
            end
         end else if ({1'b0, req_chan.slot} < (SLOT_W+1)'(NUM_AXES)) begin
            if (req_chan.value == rom.neutral) begin
               lock_in = 1'b0;
               if (abv_ff && ({1'b0, abs_ff} < (SLOT_W+1)'(NUM_BUTTONS)) &&
                   flags_ff[abs_ff[IDX_W-1:0]]) begin
                  abv_in     = 1'b0;
                  do_release = 1'b1;
                  rel_slot   = abs_ff[IDX_W-1:0];
               end
            end else if (!lock_ff) begin
               if (req_chan.value == rom.press_a) begin
                  found   = rom.has_a;
                  ax_slot = rom.slot_a;
               end else if (req_chan.value == rom.press_b) begin
                  found   = rom.has_b;
                  ax_slot = rom.slot_b;
               end
               if (found && ({1'b0, ax_slot} < (SLOT_W+1)'(NUM_BUTTONS))) begin
                  do_press   = 1'b1;
                  press_slot = ax_slot[IDX_W-1:0];
                  lock_in    = 1'b1;
                  abv_in     = 1'b1;
                  abs_in     = ax_slot;
               end
            end
         end
      end
   end

   assign hit      = flags_ff[idx_ff] && cmp.gt_thr && cmp.earlier;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in    = state_ff;
      thr_in      = csr_wr_en ? csr_wr_data : thr_ff;
      flags_in    = flags_ff;
      idx_in      = idx_ff;
      rel_slot_in = rel_slot_ff;
      time_in     = time_ff;
      pts_in      = pts_ff;
      mask_in     = mask_ff;
      rd_addr     = rel_slot;
      rsp_mask_in = rsp_mask_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || load_rsp;
      case (state_ff)
         ST_IDLE: begin
            if (do_press) begin
               flags_in[press_slot] = 1'b1;
            end
            if (do_release) begin
               flags_in[rel_slot] = 1'b0;
               rel_slot_in        = rel_slot;
               time_in            = req_chan.time_ms;
               state_in           = ST_CHK;
            end
         end
         ST_CHK: begin
            // rd_data holds the released button's press time
            rd_addr = '0;
            pts_in  = rd_data;
            mask_in = '0;
            idx_in  = '0;
            state_in = cmp.ge_thr ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr         = idx_ff + IDX_W'(1);
            mask_in[idx_ff] = hit;
            idx_in          = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rd_addr = rel_slot_ff;
            if (load_rsp) begin
               rsp_mask_in = MASK_W'(mask_ff);
               rsp_slot_in = SLOT_W'(rel_slot_ff);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         flags_ff     <= '0;
         lock_ff      <= 1'b0;
         abv_ff       <= 1'b0;
         abs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         flags_ff     <= flags_in;
         lock_ff      <= lock_in;
         abv_ff       <= abv_in;
         abs_ff       <= abs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rel_slot_ff <= rel_slot_in;
      time_ff     <= time_in;
      pts_ff      <= pts_in;
      mask_ff     <= mask_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.held_mask    = rsp_mask_ff;
   assign rsp_chan.final_button = rsp_slot_ff;

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_ff == LAST_IDX) |=> (state_ff == ST_DONE))
      else $error("scan did not end after the last slot");

   a_released_clear: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> !flags_ff[rel_slot_ff])
      else $error("released button still flagged after chord");

   a_mask_excl_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_mask_ff[rsp_slot_ff])
      else $error("chord mask holds the released button");

   a_busy_no_press: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!do_press && !do_release))
      else $error("event decoded while scanning");
endmodule

// ===== rtl/bcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/bcd_time_cmp.sv =====
// Shared wrapping time compare unit: signed 32-bit differences against
// the hold threshold and against the released press time. Uses bcd_pkg.
module bcd_time_cmp (
   input  logic [bcd_pkg::TIME_W-1:0] now_time,
   input  logic [bcd_pkg::TIME_W-1:0] ref_time,
   input  logic [bcd_pkg::TIME_W-1:0] entry_time,
   input  logic [bcd_pkg::THR_W-1:0]  threshold,
   output bcd_pkg::cmp_status_type    status
);
   import bcd_pkg::*;

   logic [TIME_W-1:0]        age;
   logic [TIME_W-1:0]        gap;
   logic signed [TIME_W:0]   age_ext;
   logic signed [TIME_W:0]   thr_ext;

   assign age     = now_time - entry_time;
   assign gap     = ref_time - entry_time;
   assign age_ext = $signed({age[TIME_W-1], age});
   assign thr_ext = $signed({{(TIME_W+1-THR_W){1'b0}}, threshold});

   assign status.ge_thr  = age_ext >= thr_ext;
   assign status.gt_thr  = age_ext > thr_ext;
   assign status.earlier = !gap[TIME_W-1] && (gap != '0);
endmodule

// ===== tb/button_chord_detector_unit_tb.sv =====
// Self-checking bench for button_chord_detector_unit: event words in, chord words out.
// Uses bcd_pkg and the channel interfaces in bcd_channels; holds its own chord predictor.
module button_chord_detector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bcd_pkg::*;

   localparam logic MODE_BUTTON = 1'b0;
   localparam logic MODE_AXIS   = 1'b1;
   localparam int   N_SLOTS       = 64;
   localparam int   N_AXIS_MAP    = 8;
   localparam int   SETTLE_CYCLES = 80;
   localparam int   IDLE_LIMIT    = 20000;
   localparam int   LONG_HOLD     = 1000;
   localparam int   N_PHASES      = 6;
   localparam int   PHASE_EVENTS  = 75;

   typedef struct packed {
      logic               mode;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  time_ms;
   } event_word_type;

   typedef struct packed {
      logic [MASK_W-1:0] held_mask;
      logic [SLOT_W-1:0] final_button;
   } chord_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] neutral;
      logic [VALUE_W-1:0] press_a;
      logic [VALUE_W-1:0] press_b;
      logic [SLOT_W-1:0]  slot_a;
      logic [SLOT_W-1:0]  slot_b;
      logic               has_a;
      logic               has_b;
   } axis_map_type;

   logic clock;
   logic reset;
   logic             csr_wr_en;
   logic [THR_W-1:0] csr_wr_data;

   bcd_req_if req_chan();
   bcd_rsp_if rsp_chan();

   button_chord_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [THR_W-1:0]  hold_thr = THR_RESET;
   logic [MASK_W-1:0] held = '0;
   logic [TIME_W-1:0] press_at [N_SLOTS];
   logic              pred_axis_hold = 1'b0;
   logic              axis_btn_valid = 1'b0;
   logic [SLOT_W-1:0] axis_btn_slot = '0;

   event_word_type pending_q [$];
   chord_word_type chord_q [$];
   event_word_type on_bus;

   // stimulus generator state
   logic [TIME_W-1:0] gen_time = 32'd5000;
   logic [MASK_W-1:0] gen_down = '0;
   int                gen_axis = -1;
   logic [SLOT_W-1:0] gen_axis_slot = '0;

   int n_queued = 0;
   int n_sent = 0;
   int n_chords = 0;
   int n_mismatch = 0;
   int n_thr_settings = 0;
   int src_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_arm = 1'b0;
   bit hold_used;
   int hold_left;
   int quiet_cycles;

   function automatic axis_map_type axis_map(input int ax);
      case (ax)
         0: return '{AX_ZERO, AX_MIN, AX_MAX, 6'd15, 6'd14, 1'b1, 1'b1};
         1: return '{AX_ZERO, AX_MIN, AX_MAX, 6'd16, 6'd17, 1'b1, 1'b1};
         2: return '{AX_MID, AX_ZERO, AX_FULL, 6'd22, 6'd0, 1'b1, 1'b0};
         3: return '{AX_ZERO, AX_MIN, AX_MAX, 6'd19, 6'd18, 1'b1, 1'b1};
         4: return '{AX_ZERO, AX_MIN, AX_MAX, 6'd20, 6'd21, 1'b1, 1'b1};
         5: return '{AX_MID, AX_ZERO, AX_FULL, 6'd23, 6'd0, 1'b1, 1'b0};
         6: return '{AX_ZERO, AX_NEG1, AX_POS1, 6'd11, 6'd10, 1'b1, 1'b1};
         7: return '{AX_ZERO, AX_NEG1, AX_POS1, 6'd12, 6'd13, 1'b1, 1'b1};
         default: return '0;
      endcase
   endfunction

   function automatic void press_slot(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] t);
      held[s] = 1'b1;
      press_at[s] = t;
   endfunction

   function automatic bit release_slot(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] t,
                                       output chord_word_type ch);
      int                thr_i;
      logic [TIME_W-1:0] t_rel;
      logic [TIME_W-1:0] d_now;
      logic [TIME_W-1:0] d_rel;
      logic [MASK_W-1:0] m;
      thr_i = int'({16'h0, hold_thr});
      t_rel = press_at[s];
      m = '0;
      ch = '0;
      held[s] = 1'b0;
      d_now = t - t_rel;
      if ($signed(d_now) >= thr_i) return 1'b0;
      for (int i = 0; i < N_SLOTS; i++) begin
         if (held[i]) begin
            d_now = t - press_at[i];
            d_rel = t_rel - press_at[i];
            if ($signed(d_now) > thr_i && $signed(d_rel) > 0) m[i] = 1'b1;
         end
      end
      ch.held_mask = m;
      ch.final_button = s;
      return 1'b1;
   endfunction

   // advance the predictor by one accepted event word
   function automatic bit apply_event(input event_word_type ev, output chord_word_type ch);
      axis_map_type      ax;
      bit                found;
      logic [SLOT_W-1:0] s;
      ch = '0;
      if (ev.mode == MODE_BUTTON) begin
         if (ev.value == BTN_PRESS) begin
            press_slot(ev.slot, ev.time_ms);
         end else if (ev.value == BTN_RELEASE && held[ev.slot]) begin
            return release_slot(ev.slot, ev.time_ms, ch);
         end
         return 1'b0;
      end
      if (ev.slot >= N_AXIS_MAP) return 1'b0;
      ax = axis_map(int'(ev.slot));
      if (ev.value == ax.neutral) begin
         pred_axis_hold = 1'b0;
         if (axis_btn_valid && held[axis_btn_slot]) begin
            axis_btn_valid = 1'b0;
            return release_slot(axis_btn_slot, ev.time_ms, ch);
         end
         return 1'b0;
      end
      if (pred_axis_hold) return 1'b0;
      found = 1'b0;
      s = '0;
      if (ev.value == ax.press_a) begin
         found = ax.has_a;
         s = ax.slot_a;
      end else if (ev.value == ax.press_b) begin
         found = ax.has_b;
         s = ax.slot_b;
      end
      if (found) begin
         press_slot(s, ev.time_ms);
         pred_axis_hold = 1'b1;
         axis_btn_valid = 1'b1;
         axis_btn_slot = s;
      end
      return 1'b0;
   endfunction

   task automatic queue_event(input logic mode, input int slot, input logic [VALUE_W-1:0] value,
                              input logic [TIME_W-1:0] t);
      event_word_type ev;
      ev.mode = mode;
      ev.slot = slot[SLOT_W-1:0];
      ev.value = value;
      ev.time_ms = t;
      pending_q.push_back(ev);
      n_queued++;
   endtask

   task automatic queue_directed();
      queue_event(MODE_BUTTON, 0, BTN_PRESS, 32'd0);
      queue_event(MODE_BUTTON, 63, BTN_PRESS, 32'd1100);
      queue_event(MODE_BUTTON, 5, BTN_PRESS, 32'd1400);
      queue_event(MODE_BUTTON, 5, BTN_RELEASE, 32'd1450);     // tap with two holders
      queue_event(MODE_BUTTON, 5, BTN_RELEASE, 32'd1460);     // not held any more
      queue_event(MODE_BUTTON, 7, BTN_PRESS, 32'd1500);
      queue_event(MODE_BUTTON, 7, BTN_PRESS, 32'd1900);       // repeated press, new time
      queue_event(MODE_BUTTON, 7, BTN_RELEASE, 32'd1950);
      queue_event(MODE_BUTTON, 1, 16'd2, 32'd1960);
      queue_event(MODE_BUTTON, 1, AX_NEG1, 32'd1970);
      queue_event(MODE_BUTTON, 1, AX_MIN, 32'd1980);
      queue_event(MODE_BUTTON, 1, AX_MAX, 32'd1990);
      queue_event(MODE_BUTTON, 63, BTN_RELEASE, 32'd2000);    // long hold, no chord
      queue_event(MODE_AXIS, 9, AX_ZERO, 32'd2010);
      queue_event(MODE_AXIS, 63, AX_MIN, 32'd2020);
      queue_event(MODE_AXIS, 0, AX_MIN, 32'd2100);
      queue_event(MODE_AXIS, 1, AX_MAX, 32'd2120);            // locked
      queue_event(MODE_AXIS, 0, 16'd5, 32'd2130);
      queue_event(MODE_AXIS, 1, AX_ZERO, 32'd2150);           // neutral frees the axis button
      queue_event(MODE_AXIS, 2, AX_FULL, 32'd2200);           // no second button
      queue_event(MODE_AXIS, 6, AX_POS1, 32'd2210);
      queue_event(MODE_BUTTON, 10, BTN_RELEASE, 32'd2220);
      queue_event(MODE_AXIS, 6, AX_ZERO, 32'd2230);           // register kept, button gone
      queue_event(MODE_BUTTON, 1, BTN_PRESS, 32'hFFFF_FFFF);
      queue_event(MODE_BUTTON, 1, BTN_RELEASE, 32'h0000_001F);
   endtask

   task automatic queue_random_event(input int thr);
      int                 r;
      int                 base;
      int                 ax;
      axis_map_type       m;
      logic [SLOT_W-1:0]  s;
      logic [VALUE_W-1:0] v;
      base = (thr < 8) ? 8 : thr;
      r = $urandom_range(99);
      if (r < 70) gen_time = gen_time + $urandom_range(base / 3, 0);
      else if (r < 85) gen_time = gen_time + $urandom_range(base * 2, base / 2);
      else if (r < 95 && r >= 90) gen_time = gen_time - $urandom_range(base, 1);
      else if (r >= 95) gen_time = $urandom;
      r = $urandom_range(99);
      if (r < 35) begin
         s = ($urandom_range(99) < 70) ? 6'($urandom_range(7) * 9) : 6'($urandom_range(63));
         gen_down[s] = 1'b1;
         queue_event(MODE_BUTTON, int'(s), BTN_PRESS, gen_time);
      end else if (r < 70) begin
         s = 6'($urandom_range(63));
         if (gen_down != '0 && $urandom_range(99) < 80) begin
            while (!gen_down[s]) s = s + 1'b1;
         end
         gen_down[s] = 1'b0;
         queue_event(MODE_BUTTON, int'(s), BTN_RELEASE, gen_time);
      end else if (r < 85) begin
         if (gen_axis < 0) begin
            ax = $urandom_range(7);
            m = axis_map(ax);
            if (m.has_b && $urandom_range(1)) begin
               v = m.press_b;
               gen_axis_slot = m.slot_b;
            end else begin
               v = m.press_a;
               gen_axis_slot = m.slot_a;
            end
            gen_axis = ax;
            gen_down[gen_axis_slot] = 1'b1;
            queue_event(MODE_AXIS, ax, v, gen_time);
         end else if ($urandom_range(99) < 70) begin
            ax = ($urandom_range(99) < 70) ? gen_axis : $urandom_range(7);
            gen_down[gen_axis_slot] = 1'b0;
            gen_axis = -1;
            m = axis_map(ax);
            queue_event(MODE_AXIS, ax, m.neutral, gen_time);
         end else begin
            ax = $urandom_range(7);
            m = axis_map(ax);
            queue_event(MODE_AXIS, ax, m.press_a, gen_time);
         end
      end else begin
         v = 16'($urandom);
         case ($urandom_range(3))
            0: begin
               if (v == BTN_PRESS || v == BTN_RELEASE) v = AX_MIN;
               queue_event(MODE_BUTTON, $urandom_range(63), v, gen_time);
            end
            1: queue_event(MODE_AXIS, $urandom_range(63, 8), v, gen_time);
            2: queue_event(MODE_AXIS, $urandom_range(7), v, gen_time);
            default: begin
               case ($urandom_range(2))
                  0: v = AX_MIN;
                  1: v = AX_MAX;
                  default: v = AX_NEG1;
               endcase
               queue_event(MODE_BUTTON, $urandom_range(63), v, gen_time);
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input logic [MASK_W-1:0] exp_v,
                                  input logic [MASK_W-1:0] act_v);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("tb: mismatch in %s: expected %h, got %h", what, exp_v, act_v);
   endtask

   // wait until every queued word is taken and every chord has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || n_sent != n_queued || chord_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hold_thr = v;
      n_thr_settings++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver: present queued event words, hold each until taken
   always @(posedge clock) begin
      chord_word_type ch;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (apply_event(on_bus, ch)) chord_q.push_back(ch);
            n_sent <= n_sent + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               on_bus = pending_q.pop_front();
               req_chan.mode <= on_bus.mode;
               req_chan.slot <= on_bus.slot;
               req_chan.value <= on_bus.value;
               req_chan.time_ms <= on_bus.time_ms;
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each chord word against the oldest prediction
   always @(posedge clock) begin
      chord_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (chord_q.size() == 0) begin
               report_mismatch("chord word with none pending", '0, rsp_chan.held_mask);
            end else begin
               want = chord_q.pop_front();
               n_chords <= n_chords + 1;
               if (rsp_chan.held_mask !== want.held_mask)
                  report_mismatch("held_mask", want.held_mask, rsp_chan.held_mask);
               if (rsp_chan.final_button !== want.final_button)
                  report_mismatch("final_button", MASK_W'(want.final_button),
                                  MASK_W'(rsp_chan.final_button));
            end
         end
         if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog: end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [THR_W-1:0] thr_val;
      int               n_now;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = 1'b0;
      req_chan.slot = '0;
      req_chan.value = '0;
      req_chan.time_ms = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();

      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (p)
            0: thr_val = 16'd0;
            1: thr_val = 16'hFFFF;
            2: thr_val = 16'd1;
            3: thr_val = 16'($urandom_range(3000, 2));
            4: thr_val = THR_RESET;
            default: thr_val = 16'($urandom);
         endcase
         write_threshold(thr_val);
         @(negedge clock);
         case (p % 4)
            0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin src_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin src_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         if (p == 1) gen_time = 32'hFFFF_0000;     // walk across the time wrap
         if (p == 5) hold_arm = 1'b1;
         n_now = (p == 4) ? PHASE_EVENTS / 2 : PHASE_EVENTS;
         for (int i = 0; i < n_now; i++) queue_random_event(int'({16'h0, thr_val}));
         if (p == 4) begin
            // stop offering until every chord so far is back
            wait_drained();
            for (int i = n_now; i < PHASE_EVENTS; i++) queue_random_event(int'({16'h0, thr_val}));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES + 20) @(posedge clock);
      $display("tb: %0d event words sent, %0d chord words checked, %0d threshold writes",
               n_sent, n_chords, n_thr_settings);
      $display("tb: idle and stall mixes, long output hold and time wrap exercised");
      if (n_mismatch == 0 && chord_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches, %0d chords missing", n_mismatch, chord_q.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bcd_pkg.sv
rtl/bcd_channels.sv
rtl/bcd_ram.sv
rtl/bcd_time_cmp.sv
rtl/button_chord_detector_unit.sv
tb/button_chord_detector_unit_tb.sv
